// ----- rtl/fmp_pkg.sv -----
package fmp_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int INDEX_BITS = 31;

    typedef logic [WORD_W-1:0] word_t;

    // 2x2 matrix, entry index is {row, col}: [0]=m00 [1]=m01 [2]=m10 [3]=m11
    typedef logic [3:0][WORD_W-1:0] mat_t;

    localparam mat_t MAT_ID = {64'd1, 64'd0, 64'd0, 64'd1};
    localparam mat_t MAT_Q  = {64'd0, 64'd1, 64'd1, 64'd1};

endpackage

// ----- rtl/fmp_matmul.sv -----
module fmp_matmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fmp_pkg::mat_t x,
    input  fmp_pkg::mat_t y,
    output fmp_pkg::mat_t r,
    output logic          done
);

    // partial product phases of one 64x64 -> 64 product
    localparam logic [1:0] PART_LL = 2'd0;  // x.lo * y.lo, full 64 bits
    localparam logic [1:0] PART_LH = 2'd1;  // x.lo * y.hi, shifted up 32
    localparam logic [1:0] PART_HL = 2'd2;  // x.hi * y.lo, shifted up 32

    logic                      busy_reg;
    logic [1:0]                ent_reg;
    logic                      term_reg;
    logic [1:0]                part_reg;

    logic [fmp_pkg::WORD_W-1:0] mul_reg;
    logic                      p_valid_reg;
    logic                      p_shift_reg;
    logic                      p_first_reg;
    logic                      p_last_reg;
    logic [1:0]                p_ent_reg;

    logic [fmp_pkg::WORD_W-1:0] acc_reg;
    fmp_pkg::mat_t             r_reg;
    logic                      done_reg;

    fmp_pkg::word_t            op_a;
    fmp_pkg::word_t            op_b;
    logic [fmp_pkg::HALF_W-1:0] mul_a;
    logic [fmp_pkg::HALF_W-1:0] mul_b;
    fmp_pkg::word_t            mul_next;
    fmp_pkg::word_t            addend;
    fmp_pkg::word_t            sum;

    // entry (i,j) += x[i][k] * y[k][j]
    assign op_a  = x[{ent_reg[1], term_reg}];
    assign op_b  = y[{term_reg, ent_reg[0]}];
    assign mul_a = (part_reg == PART_HL) ? op_a[fmp_pkg::WORD_W-1:fmp_pkg::HALF_W]
                                         : op_a[fmp_pkg::HALF_W-1:0];
    assign mul_b = (part_reg == PART_LH) ? op_b[fmp_pkg::WORD_W-1:fmp_pkg::HALF_W]
                                         : op_b[fmp_pkg::HALF_W-1:0];
    assign mul_next = mul_a * mul_b;

    assign addend = p_shift_reg ? {mul_reg[fmp_pkg::HALF_W-1:0], {fmp_pkg::HALF_W{1'b0}}}
                                : mul_reg;
    assign sum    = (p_first_reg ? '0 : acc_reg) + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            ent_reg     <= '0;
            term_reg    <= 1'b0;
            part_reg    <= PART_LL;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= busy_reg;
            done_reg    <= p_valid_reg && p_last_reg && (p_ent_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                ent_reg  <= '0;
                term_reg <= 1'b0;
                part_reg <= PART_LL;
            end
            else if (busy_reg)
            begin
                if (part_reg == PART_HL)
                begin
                    part_reg <= PART_LL;
                    if (term_reg)
                    begin
                        term_reg <= 1'b0;
                        if (ent_reg == 2'd3)
                        begin
                            busy_reg <= 1'b0;
                        end
                        else
                        begin
                            ent_reg <= ent_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        term_reg <= 1'b1;
                    end
                end
                else
                begin
                    part_reg <= part_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg     <= mul_next;
        p_shift_reg <= (part_reg != PART_LL);
        p_first_reg <= !term_reg && (part_reg == PART_LL);
        p_last_reg  <= term_reg && (part_reg == PART_HL);
        p_ent_reg   <= ent_reg;
        if (p_valid_reg)
        begin
            acc_reg <= sum;
            if (p_last_reg)
            begin
                r_reg[p_ent_reg] <= sum;
            end
        end
    end

    assign r    = r_reg;
    assign done = done_reg;

endmodule

// ----- rtl/fibonacci_matrix_power.sv -----
// Timing: for an index below 3 the result is valid in the cycle after accept. Otherwise
//   each 2x2 matrix product runs 24 partial products through one shared 32x32
//   multiplier; one product squares the power for every exponent bit below the
//   highest set bit, and one more per set bit multiplies it into the result.
// Throughput: one transaction at a time; in_stall stays high until the result leaves.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
module fibonacci_matrix_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fmp_pkg::INDEX_BITS-1:0] n_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fmp_pkg::WORD_W-1:0]     fib_value
);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;  // waiting for an index
    localparam logic [2:0] ST_BIT      = 3'd1;  // test low exponent bit
    localparam logic [2:0] ST_WAIT_ACC = 3'd2;  // acc = acc * pw in progress
    localparam logic [2:0] ST_NEXT     = 3'd3;  // more bits left? square or finish
    localparam logic [2:0] ST_WAIT_SQ  = 3'd4;  // pw = pw * pw in progress
    localparam logic [2:0] ST_OUT      = 3'd5;  // result held for the sink

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [fmp_pkg::INDEX_BITS-1:0] exp_reg;
    logic [fmp_pkg::INDEX_BITS-1:0] exp_next;
    fmp_pkg::mat_t                  acc_reg;
    fmp_pkg::mat_t                  acc_next;
    fmp_pkg::mat_t                  pw_reg;
    fmp_pkg::mat_t                  pw_next;
    fmp_pkg::word_t                 fib_reg;
    fmp_pkg::word_t                 fib_next;

    logic                           in_accept;
    logic                           small_index;
    logic                           more_bits;
    logic                           mm_start;
    logic                           mm_done;
    fmp_pkg::mat_t                  mm_x;
    fmp_pkg::mat_t                  mm_r;

    assign in_accept   = in_valid && !in_stall;
    assign small_index = (n_index < fmp_pkg::INDEX_BITS'(3));
    // bits above the current one still pending
    assign more_bits   = (exp_reg[fmp_pkg::INDEX_BITS-1:1] != '0);

    // the shared multiplier sees acc*pw or pw*pw; operands hold while it runs
    assign mm_x = (state_reg == ST_WAIT_SQ) ? pw_reg : acc_reg;

    fmp_matmul u_matmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (pw_reg),
        .r     (mm_r),
        .done  (mm_done)
    );

    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        pw_next    = pw_reg;
        fib_next   = fib_reg;
        mm_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    acc_next = fmp_pkg::MAT_ID;
                    pw_next  = fmp_pkg::MAT_Q;
                    exp_next = n_index - fmp_pkg::INDEX_BITS'(2);
                    if (small_index)
                    begin
                        // identity power, top row sums to one
                        fib_next   = fmp_pkg::word_t'(1);
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_BIT:
            begin
                if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    state_next = ST_WAIT_ACC;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_WAIT_ACC:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_r;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (more_bits)
                begin
                    mm_start   = 1'b1;
                    state_next = ST_WAIT_SQ;
                end
                else
                begin
                    // later squarings no longer reach acc
                    fib_next   = acc_reg[0] + acc_reg[1];
                    state_next = ST_OUT;
                end
            end
            ST_WAIT_SQ:
            begin
                if (mm_done)
                begin
                    pw_next    = mm_r;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_BIT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        pw_reg  <= pw_next;
        fib_reg <= fib_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign fib_value = fib_reg;

    // an open input slot never coexists with a pending result
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input ready while result pending");

    // product completion only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == ST_WAIT_ACC || state_reg == ST_WAIT_SQ))
        else $error("unexpected matrix product completion");

    // small indices answer one on the next cycle
    a_small_index: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && small_index) |=> (out_valid && fib_value == 64'd1))
        else $error("small index result wrong");

    // a product is never started while one is still running
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> (state_reg == ST_BIT || state_reg == ST_NEXT))
        else $error("matrix product started out of sequence");

endmodule
